[rtl/core/dxts_pkg.sv]
// ----------------------------------------------------------------------------
// DominoEX tone sequencer package
// Shared types, codes and small helper functions for the tone sequencer.
// ----------------------------------------------------------------------------
package dxts_pkg;

    localparam int MESSAGE_DEPTH_DEF = 128;
    localparam int TONE_COUNT        = 18;
    localparam int CODE_DEPTH        = 128;
    localparam int CHAR_W            = 7;
    localparam int CODE_W            = 15;
    localparam int SYM_W             = 5;
    localparam int TONE_W            = 5;
    localparam int OFFSET_W          = 16;
    localparam int CFG_INDEX_W       = 3;
    localparam int CFG_DATA_W        = 16;
    localparam int S_TDATA_W         = 40;
    localparam int M_TDATA_W         = 24;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_START   = 2'd1,
        OP_MSG_WR  = 2'd2,
        OP_CODE_WR = 2'd3
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SYNC_A      = 3'd0,
        CFG_SYNC_B      = 3'd1,
        CFG_SYNC_C      = 3'd2,
        CFG_SYNC_REPS   = 3'd3,
        CFG_BASE_OFFSET = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        FETCH_IDLE,
        FETCH_MSG,
        FETCH_CODE
    } fetch_state_t;

    typedef struct packed {
        logic msg_rd;
        logic code_rd;
    } fetch_ctl_t;

    typedef struct packed {
        logic [3:0]          sync_a;
        logic [3:0]          sync_b;
        logic [3:0]          sync_c;
        logic [7:0]          sync_reps;
        logic [OFFSET_W-1:0] base_offset;
    } cfg_t;

    typedef struct packed {
        logic                transmitter_on;
        logic                offset_valid;
        logic [TONE_W-1:0]   tone_index;
        logic [OFFSET_W-1:0] tone_offset;
        logic                message_done;
    } result_t;

    // Varicode 5-bit symbol field of a character at slot 0..2; slot 3 reads as missing
    function automatic logic [SYM_W-1:0] sym_field(input logic [CODE_W-1:0] code,
                                                   input logic [1:0] slot);
        logic [SYM_W-1:0] f;
        case (slot)
            2'd0:    f = code[4:0];
            2'd1:    f = code[9:5];
            2'd2:    f = code[14:10];
            default: f = 5'b10000;
        endcase
        return f;
    endfunction

    // Tone step for a symbol field: symbol + 2, a missing symbol steps by one
    function automatic logic [TONE_W-1:0] step_of(input logic [SYM_W-1:0] f);
        logic [TONE_W-1:0] s;
        if (f[SYM_W-1]) begin
            s = 5'd1;
        end else begin
            s = {1'b0, f[3:0]} + 5'd2;
        end
        return s;
    endfunction

endpackage

[rtl/core/dxts_store.sv]
// ----------------------------------------------------------------------------
// DominoEX tone sequencer message and varicode stores
// Message memory and varicode memory, each with two registered read ports
// that fetch the current and the following character of the message.
// ----------------------------------------------------------------------------
module dxts_store #(
    parameter int MESSAGE_DEPTH = dxts_pkg::MESSAGE_DEPTH_DEF,
    localparam int MAW = (MESSAGE_DEPTH > 1) ? $clog2(MESSAGE_DEPTH) : 1
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  dxts_pkg::op_t              opcode,
    input  logic [dxts_pkg::CHAR_W-1:0] entry_index,
    input  logic [dxts_pkg::CHAR_W-1:0] char_code,
    input  logic [dxts_pkg::CODE_W-1:0] code_word,
    input  dxts_pkg::fetch_ctl_t       fetch_ctl,
    input  logic [MAW-1:0]             rd_addr_cur,
    input  logic [MAW-1:0]             rd_addr_nxt,
    output logic [dxts_pkg::CODE_W-1:0] cur_code,
    output logic [dxts_pkg::CODE_W-1:0] nxt_code
);

    logic [dxts_pkg::CHAR_W-1:0] msg_mem [MESSAGE_DEPTH];
    logic [dxts_pkg::CODE_W-1:0] code_mem [dxts_pkg::CODE_DEPTH];

    logic [dxts_pkg::CHAR_W-1:0] cur_char_reg;
    logic [dxts_pkg::CHAR_W-1:0] nxt_char_reg;
    logic [dxts_pkg::CODE_W-1:0] cur_code_reg;
    logic [dxts_pkg::CODE_W-1:0] nxt_code_reg;

    logic msg_we;
    logic code_we;

    // Message writes beyond the store are dropped
    assign msg_we  = wr_en && (opcode == dxts_pkg::OP_MSG_WR) &&
                     ({1'b0, entry_index} < 8'(MESSAGE_DEPTH));
    assign code_we = wr_en && (opcode == dxts_pkg::OP_CODE_WR);

    always_ff @(posedge aclk) begin
        if (msg_we) begin
            msg_mem[entry_index[MAW-1:0]] <= char_code;
        end
        if (fetch_ctl.msg_rd) begin
            cur_char_reg <= msg_mem[rd_addr_cur];
            nxt_char_reg <= msg_mem[rd_addr_nxt];
        end
    end

    // The code read registers hold between fetches and serve as the cache
    always_ff @(posedge aclk) begin
        if (code_we) begin
            code_mem[entry_index] <= code_word;
        end
        if (fetch_ctl.code_rd) begin
            cur_code_reg <= code_mem[cur_char_reg];
            nxt_code_reg <= code_mem[nxt_char_reg];
        end
    end

    assign cur_code = cur_code_reg;
    assign nxt_code = nxt_code_reg;

endmodule

[rtl/core/dxts_seq.sv]
// ----------------------------------------------------------------------------
// DominoEX tone sequencer core
// Sync and character phase state, 18-tone accumulator, and the fetch
// sequencer that loads the varicode of the current and next character.
// ----------------------------------------------------------------------------
module dxts_seq #(
    parameter int MESSAGE_DEPTH = dxts_pkg::MESSAGE_DEPTH_DEF,
    localparam int MAW = (MESSAGE_DEPTH > 1) ? $clog2(MESSAGE_DEPTH) : 1,
    localparam int LW  = $clog2(MESSAGE_DEPTH + 1),
    localparam int CW  = MAW + 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        accept,
    input  dxts_pkg::op_t               opcode,
    input  logic [7:0]                  message_length,
    input  dxts_pkg::cfg_t              cfg,
    input  logic [dxts_pkg::CODE_W-1:0] cur_code,
    input  logic [dxts_pkg::CODE_W-1:0] nxt_code,
    output logic                        fetch_idle,
    output dxts_pkg::fetch_ctl_t        fetch_ctl,
    output logic [MAW-1:0]              rd_addr_cur,
    output logic [MAW-1:0]              rd_addr_nxt,
    output dxts_pkg::result_t           result
);

    logic                          sending_reg,   sending_next;
    logic                          in_char_reg,   in_char_next;
    logic [1:0]                    sync_slot_reg, sync_slot_next;
    logic [7:0]                    sync_cnt_reg,  sync_cnt_next;
    logic [1:0]                    sym_slot_reg,  sym_slot_next;
    logic [MAW-1:0]                char_pos_reg,  char_pos_next;
    logic [dxts_pkg::TONE_W-1:0]   tone_acc_reg,  tone_acc_next;
    logic [LW-1:0]                 len_held_reg,  len_held_next;
    dxts_pkg::fetch_state_t        fetch_state_reg, fetch_state_next;

    logic                          refetch;
    logic                          valid;
    logic                          finished;
    logic [dxts_pkg::SYM_W-1:0]    sym_f;
    logic [7:0]                    reps;
    logic [7:0]                    cnt;
    logic [7:0]                    len_sat;
    logic [CW-1:0]                 next_pos;
    logic [dxts_pkg::TONE_W:0]     acc_sum;
    logic [dxts_pkg::OFFSET_W:0]   offs;

    assign next_pos    = {1'b0, char_pos_reg} + CW'(1);
    assign rd_addr_cur = char_pos_reg;
    assign rd_addr_nxt = (next_pos < CW'(MESSAGE_DEPTH)) ? next_pos[MAW-1:0] : '0;

    always_comb begin
        sending_next   = sending_reg;
        in_char_next   = in_char_reg;
        sync_slot_next = sync_slot_reg;
        sync_cnt_next  = sync_cnt_reg;
        sym_slot_next  = sym_slot_reg;
        char_pos_next  = char_pos_reg;
        tone_acc_next  = tone_acc_reg;
        len_held_next  = len_held_reg;
        refetch        = 1'b0;
        valid          = 1'b0;
        finished       = 1'b0;
        sym_f          = '0;
        reps           = (cfg.sync_reps == 8'd0) ? 8'd1 : cfg.sync_reps;
        cnt            = sync_cnt_reg;
        acc_sum        = '0;

        if (message_length == 8'd0) begin
            len_sat = 8'd1;
        end else if (message_length > 8'(MESSAGE_DEPTH)) begin
            len_sat = 8'(MESSAGE_DEPTH);
        end else begin
            len_sat = message_length;
        end

        if (accept) begin
            unique case (opcode) inside
                dxts_pkg::OP_START: begin
                    sending_next   = 1'b1;
                    in_char_next   = 1'b0;
                    sync_slot_next = '0;
                    sync_cnt_next  = '0;
                    sym_slot_next  = '0;
                    char_pos_next  = '0;
                    len_held_next  = len_sat[LW-1:0];
                    refetch        = 1'b1;
                end
                dxts_pkg::OP_MSG_WR, dxts_pkg::OP_CODE_WR: begin
                    // a store write may touch the cached characters
                    refetch = sending_reg;
                end
                dxts_pkg::OP_TICK: begin
                    if (sending_reg) begin
                        if (!in_char_reg) begin
                            case (sync_slot_reg)
                                2'd0:    sym_f = {1'b0, cfg.sync_a};
                                2'd1:    sym_f = {1'b0, cfg.sync_b};
                                default: sym_f = {1'b0, cfg.sync_c};
                            endcase
                            if (sync_slot_reg == 2'd2) begin
                                sync_slot_next = '0;
                                cnt            = sync_cnt_reg + 8'd1;
                            end else begin
                                sync_slot_next = sync_slot_reg + 2'd1;
                            end
                            if (cnt >= reps) begin
                                in_char_next  = 1'b1;
                                sync_cnt_next = '0;
                            end else begin
                                sync_cnt_next = cnt;
                            end
                        end else begin
                            sym_f = dxts_pkg::sym_field(cur_code, sym_slot_reg);
                            if (sym_f[dxts_pkg::SYM_W-1]) begin
                                sym_slot_next = '0;
                                if (next_pos >= CW'(len_held_reg)) begin
                                    sending_next   = 1'b0;
                                    in_char_next   = 1'b0;
                                    char_pos_next  = '0;
                                    sync_slot_next = '0;
                                    sync_cnt_next  = '0;
                                    finished       = 1'b1;
                                end else begin
                                    // advance and send the next character's first symbol now
                                    char_pos_next = next_pos[MAW-1:0];
                                    sym_f         = dxts_pkg::sym_field(nxt_code, 2'd0);
                                    sym_slot_next = 2'd1;
                                    refetch       = 1'b1;
                                end
                            end else begin
                                sym_slot_next = sym_slot_reg + 2'd1;
                            end
                        end
                        if (!finished) begin
                            acc_sum = {1'b0, tone_acc_reg} + {1'b0, dxts_pkg::step_of(sym_f)};
                            if (acc_sum >= (dxts_pkg::TONE_W + 1)'(dxts_pkg::TONE_COUNT)) begin
                                acc_sum = acc_sum - (dxts_pkg::TONE_W + 1)'(dxts_pkg::TONE_COUNT);
                            end
                            tone_acc_next = acc_sum[dxts_pkg::TONE_W-1:0];
                            valid         = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        offs = {1'b0, cfg.base_offset} + {11'd0, tone_acc_next, 1'b0};
        result.transmitter_on = sending_next;
        result.offset_valid   = valid;
        result.tone_index     = tone_acc_next;
        result.tone_offset    = offs[dxts_pkg::OFFSET_W] ? '1 : offs[dxts_pkg::OFFSET_W-1:0];
        result.message_done   = finished;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sending_reg   <= 1'b0;
            in_char_reg   <= 1'b0;
            sync_slot_reg <= '0;
            sync_cnt_reg  <= '0;
            sym_slot_reg  <= '0;
            char_pos_reg  <= '0;
            tone_acc_reg  <= '0;
            len_held_reg  <= LW'(1);
        end else begin
            sending_reg   <= sending_next;
            in_char_reg   <= in_char_next;
            sync_slot_reg <= sync_slot_next;
            sync_cnt_reg  <= sync_cnt_next;
            sym_slot_reg  <= sym_slot_next;
            char_pos_reg  <= char_pos_next;
            tone_acc_reg  <= tone_acc_next;
            len_held_reg  <= len_held_next;
        end
    end

    // Fetch sequencer: read message chars, then their varicode entries
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fetch_state_reg <= dxts_pkg::FETCH_IDLE;
        end else begin
            fetch_state_reg <= fetch_state_next;
        end
    end

    always_comb begin
        fetch_state_next  = fetch_state_reg;
        fetch_ctl.msg_rd  = 1'b0;
        fetch_ctl.code_rd = 1'b0;
        fetch_idle        = 1'b0;
        unique case (fetch_state_reg)
            dxts_pkg::FETCH_IDLE: begin
                fetch_idle = 1'b1;
                if (refetch) begin
                    fetch_state_next = dxts_pkg::FETCH_MSG;
                end
            end
            dxts_pkg::FETCH_MSG: begin
                fetch_ctl.msg_rd = 1'b1;
                fetch_state_next = dxts_pkg::FETCH_CODE;
            end
            dxts_pkg::FETCH_CODE: begin
                fetch_ctl.code_rd = 1'b1;
                fetch_state_next  = dxts_pkg::FETCH_IDLE;
            end
            default: begin
                fetch_state_next = dxts_pkg::FETCH_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_no_accept_in_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> (fetch_state_reg == dxts_pkg::FETCH_IDLE))
        else $error("transaction accepted while the character cache is being refilled");

    a_fetch_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (fetch_state_reg == dxts_pkg::FETCH_MSG) |=> (fetch_state_reg == dxts_pkg::FETCH_CODE))
        else $error("varicode read did not follow message read");

    a_tone_range: assert property (@(posedge aclk) disable iff (!aresetn)
        tone_acc_reg < dxts_pkg::TONE_W'(dxts_pkg::TONE_COUNT))
        else $error("tone index out of range");

    a_pos_in_message: assert property (@(posedge aclk) disable iff (!aresetn)
        (sending_reg && in_char_reg) |-> ({1'b0, char_pos_reg} < CW'(len_held_reg)))
        else $error("character position beyond message length");

    a_done_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && result.message_done) |=> (!sending_reg && !in_char_reg))
        else $error("message finished but sequencer still sending");
`endif

endmodule

[rtl/core/dominoex_tone_sequencer_unit.sv]
// Output: a result is registered on accept and presented in the next cycle.
// Throughput: one transaction per cycle while the output is not back-pressured and no
//   fetch runs; after a start, a character change, or a store write while sending, input
//   is held off while message then varicode memory are read for the current and next character.
// Reset: synchronous, active low; clears sequencer state and output valid, sets the
//   configuration registers to defaults; message and varicode memories are not cleared.
// ----------------------------------------------------------------------------
// DominoEX tone sequencer top level
// Stream wrapper with configuration registers and the output register.
// ----------------------------------------------------------------------------
module dominoex_tone_sequencer_unit #(
    parameter int MESSAGE_DEPTH = dxts_pkg::MESSAGE_DEPTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // s_tdata: entry_index[6:0], char_code[13:7], symbol_first[18:14],
    //          symbol_second[23:19], symbol_third[28:24], message_length[36:29], zero
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [dxts_pkg::S_TDATA_W-1:0]     s_tdata,
    // s_tuser: opcode[1:0]
    input  logic [1:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // m_tdata: transmitter_on[0], tone_index[5:1], tone_offset[21:6], zero
    output logic [dxts_pkg::M_TDATA_W-1:0]     m_tdata,
    // m_tuser: offset_valid[0]
    output logic                               m_tuser,
    output logic                               m_tlast,
    input  logic                               cfg_wr_en,
    input  logic [dxts_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [dxts_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int MAW = (MESSAGE_DEPTH > 1) ? $clog2(MESSAGE_DEPTH) : 1;

    dxts_pkg::cfg_t              cfg_reg;
    dxts_pkg::result_t           result;
    dxts_pkg::result_t           result_reg;
    logic                        m_valid_reg;
    dxts_pkg::fetch_ctl_t        fetch_ctl;
    logic                        fetch_idle;
    logic                        accept;
    dxts_pkg::op_t               opcode;
    logic [MAW-1:0]              rd_addr_cur;
    logic [MAW-1:0]              rd_addr_nxt;
    logic [dxts_pkg::CODE_W-1:0] cur_code;
    logic [dxts_pkg::CODE_W-1:0] nxt_code;

    assign opcode   = dxts_pkg::op_t'(s_tuser);
    assign s_tready = (!m_valid_reg || m_tready) && fetch_idle;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_a      <= '0;
            cfg_reg.sync_b      <= '0;
            cfg_reg.sync_c      <= '0;
            cfg_reg.sync_reps   <= 8'd1;
            cfg_reg.base_offset <= '0;
        end else if (cfg_wr_en) begin
            unique case (dxts_pkg::cfg_idx_t'(cfg_index))
                dxts_pkg::CFG_SYNC_A:      cfg_reg.sync_a      <= cfg_wdata[3:0];
                dxts_pkg::CFG_SYNC_B:      cfg_reg.sync_b      <= cfg_wdata[3:0];
                dxts_pkg::CFG_SYNC_C:      cfg_reg.sync_c      <= cfg_wdata[3:0];
                dxts_pkg::CFG_SYNC_REPS:   cfg_reg.sync_reps   <= cfg_wdata[7:0];
                dxts_pkg::CFG_BASE_OFFSET: cfg_reg.base_offset <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    dxts_store #(
        .MESSAGE_DEPTH(MESSAGE_DEPTH)
    ) u_store (
        .aclk        (aclk),
        .wr_en       (accept),
        .opcode      (opcode),
        .entry_index (s_tdata[6:0]),
        .char_code   (s_tdata[13:7]),
        .code_word   ({s_tdata[28:24], s_tdata[23:19], s_tdata[18:14]}),
        .fetch_ctl   (fetch_ctl),
        .rd_addr_cur (rd_addr_cur),
        .rd_addr_nxt (rd_addr_nxt),
        .cur_code    (cur_code),
        .nxt_code    (nxt_code)
    );

    dxts_seq #(
        .MESSAGE_DEPTH(MESSAGE_DEPTH)
    ) u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .opcode         (opcode),
        .message_length (s_tdata[36:29]),
        .cfg            (cfg_reg),
        .cur_code       (cur_code),
        .nxt_code       (nxt_code),
        .fetch_idle     (fetch_idle),
        .fetch_ctl      (fetch_ctl),
        .rd_addr_cur    (rd_addr_cur),
        .rd_addr_nxt    (rd_addr_nxt),
        .result         (result)
    );

    // Output register: load on accept, drop once the transaction is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, result_reg.tone_offset, result_reg.tone_index,
                       result_reg.transmitter_on};
    assign m_tuser  = result_reg.offset_valid;
    assign m_tlast  = result_reg.message_done;

endmodule
